/* rtl/word_break_segmentation_check_macros.svh */
// Assertion macros for the word break segmentation checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef WORD_BREAK_SEGMENTATION_CHECK_MACROS_SVH
`define WORD_BREAK_SEGMENTATION_CHECK_MACROS_SVH

// Assert a property on the rising clock edge, off during reset.
`define WBSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assert that an expression never holds.
`define WBSC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* rtl/wbsc_pkg.sv */
// Shared types, opcodes and defaults of the word break segmentation check.
// No dependencies.
`default_nettype none
package wbsc_pkg;

  localparam int unsigned DictWordsDef  = 1024;
  localparam int unsigned MaxWordLenDef = 32;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DICT  = 2'd1;
  localparam logic [1:0] OP_TEXT  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic segmentable;
    logic dict_overflow;
  } res_t;

endpackage
`default_nettype wire

/* rtl/wbsc_dict.sv */
// Dictionary store: one row of bytes and one length per word.
// Uses no package items; widths come from the parameters.
`default_nettype none
module wbsc_dict #(
  parameter int unsigned DICT_WORDS   = 1024,
  parameter int unsigned MAX_WORD_LEN = 32,
  localparam int unsigned AW = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1,
  localparam int unsigned LNW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1,
  localparam int unsigned LW = $clog2(MAX_WORD_LEN + 2),
  localparam int unsigned RW = MAX_WORD_LEN * 8
) (
  input  wire logic           clk_i,
  input  wire logic           byte_we_i,
  input  wire logic [AW-1:0]  wr_row_i,
  input  wire logic [LNW-1:0] wr_lane_i,
  input  wire logic [7:0]     wr_byte_i,
  input  wire logic           len_we_i,
  input  wire logic [LW-1:0]  wr_len_i,
  input  wire logic           rd_en_i,
  input  wire logic [AW-1:0]  rd_addr_i,
  output logic      [RW-1:0]  rd_row_o,
  output logic      [LW-1:0]  rd_len_o
);

  logic [RW-1:0] row_mem [DICT_WORDS];
  logic [LW-1:0] len_mem [DICT_WORDS];

  // Write one byte lane of a word row
  always_ff @(posedge clk_i) begin
    if (byte_we_i) begin
      row_mem[wr_row_i][wr_lane_i*8 +: 8] <= wr_byte_i;
    end
  end

  // Write the length when the word ends
  always_ff @(posedge clk_i) begin
    if (len_we_i) begin
      len_mem[wr_row_i] <= wr_len_i;
    end
  end

  // Registered read of one whole word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_o <= row_mem[rd_addr_i];
      rd_len_o <= len_mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/wbsc_match.sv */
// Shared compare unit: one stored word against the text suffix.
// Uses no package items; widths come from the parameter.
`default_nettype none
module wbsc_match #(
  parameter int unsigned MAX_WORD_LEN = 32,
  localparam int unsigned LW = $clog2(MAX_WORD_LEN + 2),
  localparam int unsigned RW = MAX_WORD_LEN * 8
) (
  input  wire logic [RW-1:0]           row_i,
  input  wire logic [LW-1:0]           len_i,
  input  wire logic [RW-1:0]           text_i,
  input  wire logic [MAX_WORD_LEN:0]   reach_i,
  output logic                         match_o
);

  logic [RW-1:0]           rev_row;
  logic [RW-1:0]           shifted;
  logic [LW-1:0]           shamt;
  logic [LW-1:0]           len_m1;
  logic [MAX_WORD_LEN:0]   reach_sh;
  logic [MAX_WORD_LEN-1:0] lane_ok;
  logic                    len_ok;

  // Reverse the word so its first byte meets the oldest text byte
  always_comb begin
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      rev_row[k*8 +: 8] = row_i[(MAX_WORD_LEN-1-k)*8 +: 8];
    end
  end

  // Align the text suffix of the word length to the top lanes
  assign len_ok   = (len_i != '0) && (len_i <= LW'(MAX_WORD_LEN));
  assign shamt    = LW'(MAX_WORD_LEN) - len_i;
  assign shifted  = text_i << {shamt, 3'b000};
  assign len_m1   = len_i - LW'(1);
  assign reach_sh = reach_i >> len_m1;

  // Compare lanes inside the word, ignore the rest
  always_comb begin
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      lane_ok[k] = (k < int'(shamt)) || (rev_row[k*8 +: 8] == shifted[k*8 +: 8]);
    end
  end

  assign match_o = len_ok && reach_sh[0] && (&lane_ok);

endmodule
`default_nettype wire

/* rtl/word_break_segmentation_check.sv */
// Top level of the word break segmentation check: sequencer and windows.
// Depends on wbsc_pkg, wbsc_dict and wbsc_match.
//
// Usage: drive a word on in_i with start high; it is taken at a rising edge
// where start is high and busy is low. op selects clear dictionary,
// dictionary byte or text byte; last ends a word or the text.
// Clear and dictionary bytes finish at once: busy stays low.
// A text byte walks every stored word through one shared compare unit, one
// word per cycle from the dictionary memory read port. busy stays high
// through the walk, tail and final states (only the final state with an
// empty dictionary), and no new byte is taken until busy falls again.
// At the last text byte the result word is on res_o for one cycle with
// done_o high, registered out of the final state as the block returns to
// idle. The receiver cannot stall; the result is shown once.
// After the result the reachability and text windows restart.
// Reset empties the dictionary and the windows and clears the overflow
// flag; the word memories are not cleared and are only read once written.
`default_nettype none
module word_break_segmentation_check
  import wbsc_pkg::*;
#(
  parameter int unsigned DICT_WORDS   = DictWordsDef,
  parameter int unsigned MAX_WORD_LEN = MaxWordLenDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_i,
  output logic      done_o,
  output res_t      res_o
);

  localparam int unsigned AW  = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
  localparam int unsigned CW  = $clog2(DICT_WORDS + 1);
  localparam int unsigned LNW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int unsigned LW  = $clog2(MAX_WORD_LEN + 2);
  localparam int unsigned RW  = MAX_WORD_LEN * 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [LW-1:0]         blen_q, blen_d;
  logic                  ovf_q, ovf_d;
  logic [RW-1:0]         tw_q, tw_d;
  logic [MAX_WORD_LEN:0] reach_q, reach_d;
  logic                  last_q, last_d;
  logic                  hit_q, hit_d;
  logic                  rvld_q, rvld_d;
  logic                  done_q, done_d;
  res_t                  res_q, res_d;

  logic            accept;
  logic            rd_en;
  logic            byte_we;
  logic            len_we;
  logic [LW-1:0]   blen_inc;
  logic [RW-1:0]   rd_row;
  logic [LW-1:0]   rd_len;
  logic            match;

  assign accept   = start && (state_q == ST_IDLE);
  assign busy     = (state_q != ST_IDLE);
  assign rd_en    = (state_q == ST_WALK);
  assign blen_inc = (blen_q <= LW'(MAX_WORD_LEN)) ? (blen_q + LW'(1)) : blen_q;
  assign byte_we  = accept && (in_i.op == OP_DICT) && (cnt_q < CW'(DICT_WORDS))
                    && (blen_q < LW'(MAX_WORD_LEN));
  assign len_we   = accept && (in_i.op == OP_DICT) && (cnt_q < CW'(DICT_WORDS))
                    && in_i.last;

  wbsc_dict #(
    .DICT_WORDS  (DICT_WORDS),
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_dict (
    .clk_i    (clk_i),
    .byte_we_i(byte_we),
    .wr_row_i (cnt_q[AW-1:0]),
    .wr_lane_i(blen_q[LNW-1:0]),
    .wr_byte_i(in_i.ch),
    .len_we_i (len_we),
    .wr_len_i (blen_inc),
    .rd_en_i  (rd_en),
    .rd_addr_i(addr_q),
    .rd_row_o (rd_row),
    .rd_len_o (rd_len)
  );

  wbsc_match #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_match (
    .row_i  (rd_row),
    .len_i  (rd_len),
    .text_i (tw_q),
    .reach_i(reach_q),
    .match_o(match)
  );

  // Sequence clear, dictionary writes and the dictionary walk, and update the windows
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    blen_d  = blen_q;
    ovf_d   = ovf_q;
    tw_d    = tw_q;
    reach_d = reach_q;
    last_d  = last_q;
    hit_d   = hit_q | (rvld_q & match);
    rvld_d  = rd_en;
    done_d  = 1'b0;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.op)
            OP_CLEAR: begin
              cnt_d  = '0;
              blen_d = '0;
              ovf_d  = 1'b0;
            end
            OP_DICT: begin
              if (cnt_q < CW'(DICT_WORDS)) begin
                blen_d = blen_inc;
                if (in_i.last) begin
                  cnt_d = cnt_q + CW'(1);
                end
              end else if (in_i.last) begin
                ovf_d = 1'b1;
              end
              if (in_i.last) begin
                blen_d = '0;
              end
            end
            OP_TEXT: begin
              tw_d    = (tw_q << 8) | RW'(in_i.ch);
              last_d  = in_i.last;
              hit_d   = 1'b0;
              addr_d  = '0;
              state_d = (cnt_q == '0) ? ST_FIN : ST_WALK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        addr_d = addr_q + AW'(1);
        if ((CW'(addr_q) + CW'(1)) == cnt_q) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        reach_d = {reach_q[MAX_WORD_LEN-1:0], hit_q};
        if (last_q) begin
          done_d              = 1'b1;
          res_d.segmentable   = hit_q;
          res_d.dict_overflow = ovf_q;
          reach_d             = {{MAX_WORD_LEN{1'b0}}, 1'b1};
          tw_d                = '0;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state and windows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      addr_q  <= '0;
      cnt_q   <= '0;
      blen_q  <= '0;
      ovf_q   <= 1'b0;
      tw_q    <= '0;
      reach_q <= {{MAX_WORD_LEN{1'b0}}, 1'b1};
      last_q  <= 1'b0;
      hit_q   <= 1'b0;
      rvld_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      blen_q  <= blen_d;
      ovf_q   <= ovf_d;
      tw_q    <= tw_d;
      reach_q <= reach_d;
      last_q  <= last_d;
      hit_q   <= hit_d;
      rvld_q  <= rvld_d;
      done_q  <= done_d;
    end
  end

  // Hold the result word
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

/* rtl/wbsc_checker.sv */
// Port-level checker for the word break segmentation check, with its bind.
// Depends on wbsc_pkg and word_break_segmentation_check_macros.svh.
`default_nettype none
`include "word_break_segmentation_check_macros.svh"
module wbsc_checker
  import wbsc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire in_t  in_i,
  input wire logic done_o
);

  // A text byte makes the block busy in the following cycle
  `WBSC_ASSERT(a_text_busy, (start && !busy && in_i.op == OP_TEXT) |=> busy, "text byte not busy")
  // Dictionary, clear and unused words finish at once with no result
  `WBSC_ASSERT(a_quick, (start && !busy && in_i.op != OP_TEXT) |=> (!busy && !done_o), "quick op stalled")
  // A result follows a busy cycle and comes with the block idle
  `WBSC_ASSERT(a_done_after, done_o |-> ($past(busy) && !busy), "result out of sequence")
  // A result is shown for one cycle only
  `WBSC_ASSERT(a_done_once, done_o |=> !done_o, "result repeated")

endmodule

bind word_break_segmentation_check wbsc_checker u_wbsc_checker (.*);
`default_nettype wire

/* verif/tb_word_break_segmentation_check.sv */
// Self-checking testbench of the word break segmentation check.
// Depends on wbsc_pkg and word_break_segmentation_check.
`timescale 1ns / 100ps
`default_nettype none
module tb_word_break_segmentation_check;
  import wbsc_pkg::*;

  localparam int unsigned NWORDS = DictWordsDef;
  localparam int unsigned WLEN   = MaxWordLenDef;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_i = '0;
  logic done_o;
  res_t res_o;

  word_break_segmentation_check u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .done_o(done_o), .res_o(res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state
  logic [7:0]      wb_bytes [NWORDS][WLEN];
  logic [5:0]      wb_len [NWORDS];
  int unsigned     wb_count;
  int unsigned     wb_build;
  logic            wb_ovf;
  logic [7:0]      wb_text [WLEN];
  logic [WLEN:0]   wb_reach;
  res_t            verdicts [$];
  int              fails = 0;
  int              idle_pct = 0;

  // Apply one word to the predictor, queue a verdict at the end of text
  task automatic segment_predict(in_t w);
    logic hit;
    int unsigned l;
    bit ok;
    case (w.op)
      OP_CLEAR: begin
        wb_count = 0; wb_build = 0; wb_ovf = 1'b0;
      end
      OP_DICT: begin
        if (wb_count < NWORDS) begin
          if (wb_build < WLEN) wb_bytes[wb_count][wb_build] = w.ch;
          if (wb_build <= WLEN) wb_build++;
          if (w.last) begin
            wb_len[wb_count] = 6'(wb_build);
            wb_count++;
          end
        end else if (w.last) wb_ovf = 1'b1;
        if (w.last) wb_build = 0;
      end
      OP_TEXT: begin
        for (int i = WLEN - 1; i > 0; i--) wb_text[i] = wb_text[i-1];
        wb_text[0] = w.ch;
        hit = 1'b0;
        for (int unsigned k = 0; k < wb_count && !hit; k++) begin
          l = wb_len[k];
          if (l >= 1 && l <= WLEN && wb_reach[l-1]) begin
            ok = 1'b1;
            for (int unsigned j = 0; j < l; j++)
              if (wb_bytes[k][j] != wb_text[l-1-j]) ok = 1'b0;
            if (ok) hit = 1'b1;
          end
        end
        wb_reach = {wb_reach[WLEN-1:0], hit};
        if (w.last) begin
          verdicts.push_back('{segmentable: hit, dict_overflow: wb_ovf});
          wb_reach = 1;
          foreach (wb_text[i]) wb_text[i] = '0;
        end
      end
      default: ;
    endcase
  endtask

  // Send one word, with random sender gaps; start drops only while idling
  task automatic send_word(logic [1:0] op, logic [7:0] ch, logic last);
    in_t w;
    w = '{op: op, ch: ch, last: last};
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    segment_predict(w);
  endtask

  task automatic send_dict_word(string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_DICT, s[i], i == s.len() - 1);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_TEXT, s[i], i == s.len() - 1);
  endtask

  // Drop start, wait for all verdicts, then cover the tail latency
  task automatic drain();
    start <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk_i);
    repeat (NWORDS + 8) @(posedge clk_i);
  endtask

  // Check each verdict against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (verdicts.size() == 0) begin
        $error("unexpected verdict %b", res_o);
        fails++;
      end else begin
        if (res_o.segmentable !== verdicts[0].segmentable) begin
          $error("segmentable expected %b actual %b", verdicts[0].segmentable,
                 res_o.segmentable);
          fails++;
        end
        if (res_o.dict_overflow !== verdicts[0].dict_overflow) begin
          $error("dict_overflow expected %b actual %b", verdicts[0].dict_overflow,
                 res_o.dict_overflow);
          fails++;
        end
        void'(verdicts.pop_front());
      end
    end
  end

  // Empty dictionary, basic splits, reuse, long word, op 3, byte extremes
  task automatic test_directed();
    send_text("a");
    send_dict_word("ab");
    send_dict_word("c");
    send_text("abcab");
    send_text("abca");
    send_word(2'd3, 8'hff, 1'b1);
    send_word(OP_DICT, 8'h00, 1'b1);
    send_word(OP_DICT, 8'hff, 1'b1);
    send_word(OP_TEXT, 8'h00, 1'b0);
    send_word(OP_TEXT, 8'hff, 1'b1);
    for (int i = 0; i < WLEN + 2; i++) send_word(OP_DICT, "x", i == WLEN + 1);
    for (int i = 0; i < WLEN; i++) send_word(OP_DICT, "y", i == WLEN - 1);
    for (int i = 0; i < WLEN + 1; i++) send_word(OP_TEXT, "y", i == WLEN);
    send_word(OP_CLEAR, 8'h55, 1'b1);
    send_text("c");
  endtask

  // Fill the dictionary past capacity with one-byte words
  task automatic test_overflow();
    send_word(OP_CLEAR, 8'h00, 1'b0);
    for (int i = 0; i < NWORDS + 2; i++) send_word(OP_DICT, 8'(i), 1'b1);
    send_word(OP_TEXT, 8'h07, 1'b1);
    send_word(OP_CLEAR, 8'h00, 1'b0);
    send_text("q");
  endtask

  // Small alphabet dictionaries and texts, plus noise
  task automatic test_random(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      send_word(OP_CLEAR, 8'($urandom), 1'($urandom));
      sent++;
      for (int k = $urandom_range(1, 6); k > 0; k--) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          send_word(OP_DICT, 8'($urandom_range(0, 2)) ^ (($urandom_range(9) == 0) ?
                    8'hfc : 8'h00), i == len - 1);
        sent += len;
      end
      for (int t = $urandom_range(1, 4); t > 0; t--) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          send_word(OP_TEXT, ($urandom_range(9) == 0) ? 8'($urandom) :
                    8'($urandom_range(0, 2)), i == len - 1);
        sent += len;
      end
      if ($urandom_range(5) == 0) begin
        send_word(2'd3, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    foreach (wb_text[i]) wb_text[i] = '0;
    wb_count = 0; wb_build = 0; wb_ovf = 1'b0; wb_reach = 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 35;
    test_directed();
    test_overflow();
    drain();
    test_random(200);
    idle_pct = 69;
    test_random(200);
    idle_pct = 0;
    test_random(180);
    drain();
    if (fails == 0 && verdicts.size() == 0) begin
      $display("word_break_segmentation_check regression: pass");
    end else begin
      $display("word_break_segmentation_check regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("word_break_segmentation_check regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
